// File: rtl/zsd_pkg.sv
// Shared definitions for the z-score step and jump detector.
// Holds the sequencer states, configuration codes, widths and reset values.
// No dependencies.
`default_nettype none

package zsd_pkg;

  // Default sizing of the block.
  localparam int WINDOW_DEFAULT      = 10;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  // Configuration register widths.
  localparam int K_BITS         = 4;
  localparam int F_BITS         = 9;
  localparam int THR_BITS       = 15;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEV_MULT  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INFLUENCE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JUMP_THR  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_THR  = 2'd3;

  // Configuration reset values.
  localparam logic [K_BITS-1:0]   DEV_MULT_RESET  = 4'd3;
  localparam logic [F_BITS-1:0]   INFLUENCE_RESET = 9'd205;
  localparam logic [THR_BITS-1:0] JUMP_THR_RESET  = 15'd512;
  localparam logic [THR_BITS-1:0] STEP_THR_RESET  = 15'd77;

  // Full blend weight (the sample alone).
  localparam logic [F_BITS-1:0] INFLUENCE_FULL = 9'd256;

  // Detection codes.
  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_STEP = 2'd1;
  localparam logic [1:0] SIG_JUMP = 2'd2;

  // Sequencer states, one item at a time.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC1,
    S_CALC2,
    S_CALC3,
    S_CALC4,
    S_CALC5,
    S_SQUARE,
    S_WRITE,
    S_DONE
  } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/zsd_ram.sv
// Generic single-clock RAM: one write port and one read port, registered read.
// Used for the filtered sample window. No dependencies.
`default_nettype none

module zsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered; a read of the entry being written
  // in the same cycle returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/zscore_step_jump_detector.sv
// Top level of the z-score step and jump detector: sequencer, arithmetic and sums.
// Depends on zsd_pkg and on zsd_ram, which holds the filtered window.
//
//   channel   signals                          direction  moves
//   input     in_valid, in_ready, sample       in         one gyro sample per item
//   output    out_valid, out_ready, signal,    out        one detection per item
//             outlier
//   config    cfg_write, cfg_index, cfg_data   in         one register write per cycle
//
// An item that meets a non-empty window walks S_CALC1 to S_CALC5, S_SQUARE and S_WRITE
// before the next item can be taken, as the sequencer follows the chain of multiplies
// and the two window reads through the single RAM read port. An item that meets an
// empty window walks S_SQUARE and S_WRITE, and a warm-up item goes straight to S_DONE.
// Reset clears the counters, the sums and the output valid flag; the window RAM is
// not cleared, since no entry is read before it is written.
// The result sits in an output register, so a stalled output only holds the block
// once a second result is ready to be loaded.
`default_nettype none

module zscore_step_jump_detector
  import zsd_pkg::*;
#(
  parameter int WINDOW      = WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]    sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic             [1:0]                signal,
  output logic                                  outlier,
  input  wire logic                             cfg_write,
  input  wire logic        [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic        [CFG_DATA_BITS-1:0]  cfg_data
);

  // Derived widths.
  localparam int SB   = SAMPLE_BITS;
  localparam int NB   = $clog2(WINDOW + 1);
  localparam int SLB  = $clog2(WINDOW);
  localparam int SUMB = SB + NB;
  localparam int QB   = 2 * SB + NB;
  localparam int NRB  = SB + NB;
  localparam int NQB  = NB + QB;
  localparam int K2B  = 2 * K_BITS;
  localparam int KVB  = NQB + K2B;
  localparam int TB   = NB + THR_BITS;
  localparam int CMPB = (NRB > TB) ? NRB : TB;
  localparam int MXB  = SB + F_BITS + 1;
  localparam int SQB  = 2 * SB;

  // Configuration registers.
  logic [K_BITS-1:0]   dev_mult;
  logic [F_BITS-1:0]   influence;
  logic [THR_BITS-1:0] jump_thr;
  logic [THR_BITS-1:0] step_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_mult  <= DEV_MULT_RESET;
      influence <= INFLUENCE_RESET;
      jump_thr  <= JUMP_THR_RESET;
      step_thr  <= STEP_THR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEV_MULT:  dev_mult  <= cfg_data[K_BITS-1:0];
        CFG_INFLUENCE: influence <= cfg_data[F_BITS-1:0];
        CFG_JUMP_THR:  jump_thr  <= cfg_data[THR_BITS-1:0];
        CFG_STEP_THR:  step_thr  <= cfg_data[THR_BITS-1:0];
        default:       dev_mult  <= dev_mult;
      endcase
    end
  end

  // Control state.
  seq_state_t         state, state_next;
  logic [NB-1:0]      warmup_count;
  logic [NB-1:0]      fill;
  logic [SLB-1:0]     slot;
  logic [SUMB-1:0]    run_sum;
  logic [QB-1:0]      run_sq_sum;

  // Datapath registers for the item in flight.
  logic [SB-1:0]      rect;
  logic [SB-1:0]      newest;
  logic [SB-1:0]      old_entry;
  logic [NRB-1:0]     nr;
  logic [2*SUMB-1:0]  s2;
  logic [NRB-1:0]     dist_abs;
  logic               pos;
  logic [NQB-1:0]     nq;
  logic [NQB-1:0]     lhs;
  logic [NQB-1:0]     var_q;
  logic [TB-1:0]      njt;
  logic [TB-1:0]      nst;
  logic [K2B-1:0]     k2;
  logic [SQB-1:0]     old_sq;
  logic [KVB-1:0]     kvar;
  logic [1:0]         sig_cand;
  logic [MXB-1:0]     mix_a;
  logic [MXB-1:0]     mix_b;
  logic [SB-1:0]      wval;
  logic [SQB-1:0]     wval_sq;
  logic [1:0]         res_sig;
  logic               res_out;

  // Window RAM ports.
  logic               ram_we;
  logic [SLB-1:0]     ram_raddr;
  logic [SB-1:0]      ram_rdata;

  // Helper values.
  logic               in_fire;
  logic               out_free;
  logic               warming;
  logic               full;
  logic [SLB-1:0]     prev_slot;
  logic [SLB-1:0]     slot_inc;
  logic [SB-1:0]      rect_in;
  logic [F_BITS-1:0]  f_sat;
  logic [MXB-1:0]     mix_sum;
  logic               out_band;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign warming   = warmup_count < NB'(WINDOW);
  assign full      = fill == NB'(WINDOW);
  assign prev_slot = (slot == '0) ? SLB'(WINDOW - 1) : slot - SLB'(1);
  assign slot_inc  = (slot == SLB'(WINDOW - 1)) ? '0 : slot + SLB'(1);
  // Negative samples become their magnitude, all others become zero.
  assign rect_in   = sample[SB-1] ? SB'(~sample + SB'(1)) : '0;
  assign f_sat     = (influence > INFLUENCE_FULL) ? INFLUENCE_FULL : influence;
  assign mix_sum   = mix_a + mix_b + MXB'(128);
  // var*k2 < dist^2 is the integer form of |r - mean| > k * deviation.
  assign out_band  = kvar < KVB'(lhs);

  // The newest entry is read at acceptance, the oldest in the cycle after it.
  assign ram_raddr = (state == S_IDLE) ? prev_slot : slot;

  zsd_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (wval),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (warming) begin
            state_next = S_DONE;
          end else if (fill == '0) begin
            state_next = S_SQUARE;
          end else begin
            state_next = S_CALC1;
          end
        end
      end
      S_CALC1:  state_next = S_CALC2;
      S_CALC2:  state_next = S_CALC3;
      S_CALC3:  state_next = S_CALC4;
      S_CALC4:  state_next = S_CALC5;
      S_CALC5:  state_next = S_SQUARE;
      S_SQUARE: state_next = S_WRITE;
      S_WRITE: begin
        ram_we     = 1'b1;
        state_next = out_free ? S_IDLE : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Counters, ring pointer and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_count <= '0;
      fill         <= '0;
      slot         <= '0;
      run_sum      <= '0;
      run_sq_sum   <= '0;
    end else begin
      if (in_fire && warming) begin
        warmup_count <= warmup_count + NB'(1);
      end
      if (state == S_WRITE) begin
        // A full window drops its oldest entry from both sums.
        run_sum    <= run_sum - (full ? SUMB'(old_entry) : '0) + SUMB'(wval);
        run_sq_sum <= run_sq_sum - (full ? QB'(old_sq) : '0) + QB'(wval_sq);
        if (!full) begin
          fill <= fill + NB'(1);
        end
        slot <= slot_inc;
      end
    end
  end

  // Arithmetic chain, one multiply deep per stage.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          rect    <= rect_in;
          wval    <= rect_in;
          res_sig <= SIG_NONE;
          res_out <= 1'b0;
        end
      end
      S_CALC1: begin
        newest <= ram_rdata;
        nr     <= NRB'(NRB'(fill) * NRB'(rect));
        s2     <= (2*SUMB)'((2*SUMB)'(run_sum) * (2*SUMB)'(run_sum));
      end
      S_CALC2: begin
        old_entry <= ram_rdata;
        dist_abs  <= (nr >= NRB'(run_sum)) ? nr - NRB'(run_sum) : NRB'(run_sum) - nr;
        pos       <= nr > NRB'(run_sum);
        nq        <= NQB'(NQB'(fill) * NQB'(run_sq_sum));
      end
      S_CALC3: begin
        lhs    <= NQB'(NQB'(dist_abs) * NQB'(dist_abs));
        var_q  <= (nq > NQB'(s2)) ? nq - NQB'(s2) : '0;
        njt    <= TB'(TB'(fill) * TB'(jump_thr));
        nst    <= TB'(TB'(fill) * TB'(step_thr));
        k2     <= K2B'(K2B'(dev_mult) * K2B'(dev_mult));
        old_sq <= SQB'(SQB'(old_entry) * SQB'(old_entry));
      end
      S_CALC4: begin
        kvar  <= KVB'(KVB'(var_q) * KVB'(k2));
        mix_a <= MXB'(MXB'(f_sat) * MXB'(rect));
        mix_b <= MXB'(MXB'(INFLUENCE_FULL - f_sat) * MXB'(newest));
        // Only an excess above the mean can be a step or a jump.
        if (pos && (CMPB'(dist_abs) > CMPB'(njt))) begin
          sig_cand <= SIG_JUMP;
        end else if (pos && (CMPB'(dist_abs) > CMPB'(nst))) begin
          sig_cand <= SIG_STEP;
        end else begin
          sig_cand <= SIG_NONE;
        end
      end
      S_CALC5: begin
        // An outlier is stored as a rounded blend with the newest entry.
        wval    <= out_band ? mix_sum[SB+7:8] : rect;
        res_sig <= out_band ? sig_cand : SIG_NONE;
        res_out <= out_band;
      end
      S_SQUARE: begin
        wval_sq <= SQB'(SQB'(wval) * SQB'(wval));
      end
      default: begin
        wval_sq <= wval_sq;
      end
    endcase
  end

  // Output register, loaded once per item when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_WRITE || state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WRITE || state == S_DONE) && out_free) begin
      signal  <= res_sig;
      outlier <= res_out;
    end
  end

endmodule

`default_nettype wire

// File: bench/zsd_checker.sv
// Checker for the z-score step and jump detector: watches the sample, result and
// configuration ports, predicts each detection and compares it with the block.
// Depends on zsd_pkg for the register indexes, reset values and detection codes.
module zsd_checker
  import zsd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [15:0]        sample,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic        [1:0]         signal,
  input  logic                      outlier,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        mismatches,
  output int                        pending
);

  localparam int WIN    = WINDOW_DEFAULT;
  localparam int QDEPTH = 8;

  typedef struct packed {
    logic [1:0] signal;
    logic       outlier;
  } detection_t;

  // Shadow copies of the configuration registers.
  logic [K_BITS-1:0]   dev_mult;
  logic [F_BITS-1:0]   influence;
  logic [THR_BITS-1:0] jump_thr;
  logic [THR_BITS-1:0] step_thr;

  // Shadow copy of the detector state.
  int          warm_seen;
  logic [63:0] win_mem [WIN];
  int          win_fill;
  int          win_slot;
  logic [63:0] win_sum;
  logic [63:0] win_sqsum;

  // Expected detections in order, as a small ring with running counts.
  detection_t  expected_fifo [QDEPTH];
  int          exp_wr;
  int          exp_rd;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Write one filtered entry into the ring; a full ring drops its oldest entry.
  function automatic void push_entry(input logic [63:0] v);
    if (win_fill >= WIN) begin
      win_sum   -= win_mem[win_slot];
      win_sqsum -= win_mem[win_slot] * win_mem[win_slot];
    end else begin
      win_fill++;
    end
    win_mem[win_slot] = v;
    win_sum   += v;
    win_sqsum += v * v;
    win_slot  = (win_slot + 1) % WIN;
  endfunction

  // Predict the detection for one accepted sample and update the window.
  function automatic detection_t detect_sample(input logic signed [15:0] s);
    int          sval;
    logic [63:0] mag, n, nq, s2, spread, nr, dist_abs, lhs, k2, excess, f, newest, mix;
    logic        outside;
    detection_t  d;
    d.signal  = SIG_NONE;
    d.outlier = 1'b0;
    sval = s;
    mag  = (sval < 0) ? 64'(-sval) : 64'd0;
    if (warm_seen < WIN) begin
      warm_seen++;
    end else if (win_fill == 0) begin
      push_entry(mag);
    end else begin
      n        = 64'(win_fill);
      nq       = n * win_sqsum;
      s2       = win_sum * win_sum;
      spread   = (nq > s2) ? nq - s2 : 64'd0;
      nr       = n * mag;
      dist_abs = (nr >= win_sum) ? nr - win_sum : win_sum - nr;
      lhs      = dist_abs * dist_abs;
      k2       = 64'(dev_mult) * 64'(dev_mult);
      // Squared form of |r - mean| > k * deviation, without a square root.
      if (lhs == 0) outside = 1'b0;
      else if (k2 == 0) outside = 1'b1;
      else outside = spread <= (lhs - 1) / k2;
      if (outside) begin
        d.outlier = 1'b1;
        if (nr > win_sum) begin
          excess = nr - win_sum;
          if (excess > n * 64'(jump_thr)) d.signal = SIG_JUMP;
          else if (excess > n * 64'(step_thr)) d.signal = SIG_STEP;
        end
        // Blend the outlier with the newest entry, rounding half up.
        f      = (influence > INFLUENCE_FULL) ? 64'(INFLUENCE_FULL) : 64'(influence);
        newest = win_mem[(win_slot + WIN - 1) % WIN];
        mix    = (f * mag + (64'd256 - f) * newest + 64'd128) >> 8;
        push_entry(mix);
      end else begin
        push_entry(mag);
      end
    end
    return d;
  endfunction

  // Track configuration writes, predict on accepted samples, compare accepted results.
  always @(posedge clk) begin
    detection_t want;
    if (rst) begin
      dev_mult  = DEV_MULT_RESET;
      influence = INFLUENCE_RESET;
      jump_thr  = JUMP_THR_RESET;
      step_thr  = STEP_THR_RESET;
      warm_seen = 0;
      win_fill  = 0;
      win_slot  = 0;
      win_sum   = 0;
      win_sqsum = 0;
      exp_wr    = 0;
      exp_rd    = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_DEV_MULT:  dev_mult  = cfg_data[K_BITS-1:0];
          CFG_INFLUENCE: influence = cfg_data[F_BITS-1:0];
          CFG_JUMP_THR:  jump_thr  = cfg_data[THR_BITS-1:0];
          CFG_STEP_THR:  step_thr  = cfg_data[THR_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          report_mismatch($sformatf("result with nothing expected (signal %0d outlier %0b)",
                                    signal, outlier));
        end else begin
          want = expected_fifo[exp_rd % QDEPTH];
          exp_rd++;
          if (signal !== want.signal) begin
            report_mismatch($sformatf("signal is %0d, expected %0d", signal, want.signal));
          end
          if (outlier !== want.outlier) begin
            report_mismatch($sformatf("outlier is %0b, expected %0b", outlier, want.outlier));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (exp_wr - exp_rd >= QDEPTH) begin
          report_mismatch("too many items accepted without a result");
        end
        expected_fifo[exp_wr % QDEPTH] = detect_sample(sample);
        exp_wr++;
      end
    end
    pending = exp_wr - exp_rd;
  end

endmodule

// File: bench/tb_top.sv
// Top of the testbench for the z-score step and jump detector: clock, reset, sample
// stimulus, configuration phases, output stalls and the verdict.
// Depends on zsd_pkg, zscore_step_jump_detector and zsd_checker.
module tb_top;
  import zsd_pkg::*;

  localparam int PHASE_ITEMS = 200;
  localparam int PHASES      = 8;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [15:0]        sample;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                signal;
  logic                      outlier;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        mismatches;
  int                        pending;
  int                        baseline;

  zscore_step_jump_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .signal    (signal),
    .outlier   (outlier),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  zsd_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .signal     (signal),
    .outlier    (outlier),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Output side: out_ready follows one of four stall patterns, picked at random.
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (cyc % 8 == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
      cyc++;
    end
  end

  // Present one item and hold it until it is accepted; returns at a falling edge.
  task automatic push_sample(input logic signed [15:0] v);
    sample   <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Write all four registers on consecutive cycles.
  task automatic apply_settings(input int k, input int f, input int jump, input int step);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEV_MULT;
    cfg_data  <= CFG_DATA_BITS'(k);
    @(negedge clk);
    cfg_index <= CFG_INFLUENCE;
    cfg_data  <= CFG_DATA_BITS'(f);
    @(negedge clk);
    cfg_index <= CFG_JUMP_THR;
    cfg_data  <= CFG_DATA_BITS'(jump);
    @(negedge clk);
    cfg_index <= CFG_STEP_THR;
    cfg_data  <= CFG_DATA_BITS'(step);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Half the time a quiet signal near a baseline, else steps and jumps on top, positive samples or noise.
  function automatic logic signed [15:0] next_sample();
    int p;
    int mag;
    p = $urandom_range(0, 99);
    if (p < 50) mag = baseline + $urandom_range(0, 8);
    else if (p < 62) return 16'($urandom_range(0, 32767));
    else if (p < 80) mag = baseline + $urandom_range(40, 600);
    else if (p < 90) mag = $urandom_range(600, 32768);
    else return 16'($urandom());
    return 16'(-mag);
  endfunction

  // Wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  initial begin
    logic signed [15:0] directed [$];
    int burst_left;
    int gap;
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample    = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_DEV_MULT;
    cfg_data  = '0;
    baseline  = 20;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Warm-up with the field extremes, then the empty window, steps, jumps,
    // positive samples and small outliers below the step threshold.
    directed = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1, 16'sh5555, 16'shAAAA,
                 16'sh0001, -16'sd256, 16'sh00FF, 16'shFF00,
                 16'sh0000, -16'sd256, 16'sh8000, 16'sd100, -16'sd2, -16'sd10,
                 -16'sd10, -16'sd10, -16'sd12, 16'sh0000, 16'sh0000, -16'sd100,
                 -16'sd600, 16'sh7FFF};
    foreach (directed[i]) push_sample(directed[i]);
    drain();

    burst_left = 1;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: apply_settings(0, 256, 0, 0);
        2: apply_settings(15, 511, 32767, 32767);
        3: apply_settings(1, 0, 300, 40);
        4: apply_settings(2, 300, 1000, 1000);
        default: apply_settings($urandom_range(0, 15), $urandom_range(0, 511),
                                $urandom_range(0, 2000), $urandom_range(0, 700));
      endcase
      baseline = $urandom_range(0, 300);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        push_sample(next_sample());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = $urandom_range(0, 10);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
      end
      drain();
    end

    // Let any stray result show up before the verdict.
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
